// ----- hw/rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int NUM_W = 32;   // numerator port width
    localparam int DEN_W = 31;   // denominator port width
    localparam int RES_W = 64;   // result numerator width

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    // one classified job as it travels from front to back
    typedef struct packed {
        t_kind                    kind;
        logic signed [NUM_W-1:0]  an;
        logic        [DEN_W-1:0]  ad;
        logic signed [NUM_W-1:0]  bn;
        logic        [DEN_W-1:0]  bd;
        logic                     bad;   // zero denominator (bd only outside divide) or division by zero
    } t_job;

    // front to queue write request
    typedef struct packed {
        logic  push;
        t_job  job;
    } t_job_wr;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_ABS,
        ST_GCD,
        ST_SHIFT,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front
// Accepts input words, trims operands to the configured width and flags
// jobs whose result is invalid.
// ----------------------------------------------------------------------------
module rau_front #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                              i_push,
    input  logic                              i_q_full,
    input  logic [1:0]                        i_kind,
    input  logic signed [rau_pkg::NUM_W-1:0]  i_a_num,
    input  logic [rau_pkg::DEN_W-1:0]         i_a_den,
    input  logic signed [rau_pkg::NUM_W-1:0]  i_b_num,
    input  logic [rau_pkg::DEN_W-1:0]         i_b_den,
    output rau_pkg::t_job_wr                  o_wr
);

    localparam int SH = rau_pkg::NUM_W - OPERAND_WIDTH;
    localparam logic [rau_pkg::DEN_W-1:0] DEN_MASK =
        rau_pkg::DEN_W'((64'd1 << (OPERAND_WIDTH - 1)) - 64'd1);

    logic signed [rau_pkg::NUM_W-1:0] a_sh;
    logic signed [rau_pkg::NUM_W-1:0] b_sh;
    rau_pkg::t_job                    job;

    // sign-extend numerators, mask denominators, classify
    always_comb begin
        a_sh     = i_a_num <<< SH;
        b_sh     = i_b_num <<< SH;
        job.kind = rau_pkg::t_kind'(i_kind);
        job.an   = a_sh >>> SH;
        job.bn   = b_sh >>> SH;
        job.ad   = i_a_den & DEN_MASK;
        job.bd   = i_b_den & DEN_MASK;
        if (job.kind == rau_pkg::KIND_DIV) begin
            job.bad = (job.ad == '0) || (job.bn == '0);
        end else begin
            job.bad = (job.ad == '0) || (job.bd == '0);
        end
        o_wr.job  = job;
        o_wr.push = i_push && !i_q_full;
    end

endmodule

// ----- hw/rtl/rau_fifo.sv -----
// ----------------------------------------------------------------------------
// rau_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module rau_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_job_wr  i_wr,
    input  logic              i_pop,
    output rau_pkg::t_job     o_job,
    output logic              o_full,
    output logic              o_empty
);

    rau_pkg::t_job  r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_pop;

    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // store word
    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wp] <= i_wr.job;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr.push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr.push) - 2'(do_pop);
        end
    end

endmodule

// ----- hw/rtl/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back
// Executes one job: three shared multiplies, binary gcd, two exact
// bit-serial divisions, and a one-word result register.
// ----------------------------------------------------------------------------
module rau_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rau_pkg::t_job                      i_job,
    input  logic                               i_q_empty,
    output logic                               o_q_pop,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [rau_pkg::RES_W-1:0]   o_res_num,
    output logic [rau_pkg::RES_W-2:0]          o_res_den,
    output logic                               o_valid_res
);

    localparam int W = rau_pkg::RES_W;

    rau_pkg::t_state       r_state;
    rau_pkg::t_state       n_state;
    rau_pkg::t_job         r_job;
    logic signed [W-1:0]   r_p0;
    logic signed [W-1:0]   r_p1;
    logic signed [W-1:0]   r_den;
    logic signed [W-1:0]   r_num;
    logic [W-1:0]          r_x;
    logic [W-1:0]          r_y;
    logic [5:0]            r_k;
    logic [W-1:0]          r_dn;
    logic [W-1:0]          r_dd;
    logic [W-1:0]          r_rn;
    logic [W-1:0]          r_rd;
    logic [5:0]            r_cnt;
    logic                  r_neg;
    logic                  r_ok;
    logic                  r_out_full;
    logic signed [W-1:0]   r_res_num;
    logic [W-2:0]          r_res_den;
    logic                  r_res_ok;

    logic signed [32:0]    mx;
    logic signed [32:0]    my;
    logic signed [65:0]    prod;
    logic                  out_load;
    logic [2*W-1:0]        step_n;
    logic [2*W-1:0]        step_d;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? (W'(0) - W'(v)) : W'(v);
    endfunction

    // one restoring step: returns {remainder, shifted dividend/quotient}
    function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                                input logic [W-1:0] dvd,
                                                input logic [W-1:0] d);
        logic [W:0] t;
        logic       ge;
        t  = {rem, dvd[W-1]};
        ge = (t >= {1'b0, d});
        if (ge) begin
            t = t - {1'b0, d};
        end
        div_step = {t[W-1:0], dvd[W-2:0], ge};
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rau_pkg::ST_IDLE:  if (!i_q_empty) n_state = rau_pkg::ST_MUL0;
            rau_pkg::ST_MUL0:  n_state = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1:  n_state = rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2:  n_state = rau_pkg::ST_SUM;
            rau_pkg::ST_SUM:   n_state = rau_pkg::ST_ABS;
            rau_pkg::ST_ABS: begin
                if (r_job.bad || r_num == '0) n_state = rau_pkg::ST_DONE;
                else n_state = rau_pkg::ST_GCD;
            end
            rau_pkg::ST_GCD:   if (r_x == '0) n_state = rau_pkg::ST_SHIFT;
            rau_pkg::ST_SHIFT: n_state = rau_pkg::ST_DIV;
            rau_pkg::ST_DIV:   if (r_cnt == '0) n_state = rau_pkg::ST_DONE;
            rau_pkg::ST_DONE:  if (!r_out_full) n_state = rau_pkg::ST_IDLE;
            default:           n_state = rau_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop  = (r_state == rau_pkg::ST_IDLE) && !i_q_empty;
        out_load = (r_state == rau_pkg::ST_DONE) && !r_out_full;
    end

    // select multiplier operands
    always_comb begin
        mx = 33'sd0;
        my = 33'sd0;
        case (r_state)
            rau_pkg::ST_MUL0: begin
                mx = {r_job.an[31], r_job.an};
                my = (r_job.kind == rau_pkg::KIND_MUL) ? {r_job.bn[31], r_job.bn}
                                                        : $signed({2'b00, r_job.bd});
            end
            rau_pkg::ST_MUL1: begin
                mx = {r_job.bn[31], r_job.bn};
                my = $signed({2'b00, r_job.ad});
            end
            rau_pkg::ST_MUL2: begin
                mx = $signed({2'b00, r_job.ad});
                my = (r_job.kind == rau_pkg::KIND_DIV) ? {r_job.bn[31], r_job.bn}
                                                        : $signed({2'b00, r_job.bd});
            end
            default: ;
        endcase
        prod   = mx * my;
        step_n = div_step(r_rn, r_dn, r_y);
        step_d = div_step(r_rd, r_dd, r_y);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::ST_IDLE: r_job <= i_job;
            rau_pkg::ST_MUL0: r_p0  <= prod[W-1:0];
            rau_pkg::ST_MUL1: r_p1  <= prod[W-1:0];
            rau_pkg::ST_MUL2: r_den <= prod[W-1:0];
            rau_pkg::ST_SUM: begin
                case (r_job.kind)
                    rau_pkg::KIND_ADD: r_num <= r_p0 + r_p1;
                    rau_pkg::KIND_SUB: r_num <= r_p0 - r_p1;
                    default:           r_num <= r_p0;
                endcase
            end
            rau_pkg::ST_ABS: begin
                r_k <= '0;
                if (r_job.bad || r_num == '0) begin
                    r_dn  <= '0;
                    r_dd  <= W'(1);
                    r_neg <= 1'b0;
                    r_ok  <= !r_job.bad;
                end else begin
                    r_x   <= mag(r_num);
                    r_y   <= mag(r_den);
                    r_dn  <= mag(r_num);
                    r_dd  <= mag(r_den);
                    r_neg <= r_num[W-1] ^ r_den[W-1];
                    r_ok  <= 1'b1;
                end
            end
            rau_pkg::ST_GCD: begin
                if (r_x != '0) begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + 6'd1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= (r_x - r_y) >> 1;
                    end else begin
                        r_y <= (r_y - r_x) >> 1;
                    end
                end
            end
            rau_pkg::ST_SHIFT: begin
                r_dn  <= r_dn >> r_k;
                r_dd  <= r_dd >> r_k;
                r_rn  <= '0;
                r_rd  <= '0;
                r_cnt <= 6'd63;
            end
            rau_pkg::ST_DIV: begin
                r_rn  <= step_n[2*W-1:W];
                r_dn  <= step_n[W-1:0];
                r_rd  <= step_d[2*W-1:W];
                r_dd  <= step_d[W-1:0];
                r_cnt <= r_cnt - 6'd1;
            end
            default: ;
        endcase
    end

    // hold result word until popped
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res_num <= r_neg ? (W'(0) - r_dn) : r_dn;
            r_res_den <= r_dd[W-2:0];
            r_res_ok  <= r_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (out_load) begin
            r_out_full <= 1'b1;
        end else if (i_pop) begin
            r_out_full <= 1'b0;
        end
    end

    assign o_empty     = !r_out_full;
    assign o_res_num   = r_res_num;
    assign o_res_den   = r_res_den;
    assign o_valid_res = r_res_ok;

`ifndef SYNTHESIS
    a_gcd_y_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rau_pkg::ST_GCD) |-> (r_y != '0))
        else $error("gcd operand y reached zero");
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rau_pkg::ST_DIV) |-> r_y[0])
        else $error("divisor is not the odd gcd part");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_full && !i_pop) |=> (r_out_full && $stable(r_res_num)))
        else $error("stalled result word changed");
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !r_out_full)
        else $error("result loaded over a waiting word");
`endif

endmodule

// ----- hw/rtl/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact fraction add, subtract, multiply and divide with gcd reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive the operation and two fractions and raise push; a word
//   is taken at a clock edge with push high and full low. A two-entry job
//   queue sits behind the front, so up to two words are taken while the
//   back is busy.
//   Result queue: while empty is low the reduced fraction and its valid flag
//   are on the outputs; pop with empty low takes it. A waiting result holds
//   until popped; the back then stalls in its final state, the job queue
//   fills and full rises.
//   Steps per word: three multiplies on one shared 33x33 multiplier, sum
//   and sign, the binary gcd loop at one step a cycle, a shift, two parallel
//   bit-serial dividers and the output state; the gcd loop and the dividers
//   set the run time. Invalid or zero results skip gcd and divide.
//   Reset empties both queues and returns the back to idle.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_kind,
    input  logic signed [rau_pkg::NUM_W-1:0]  i_a_num,
    input  logic [rau_pkg::DEN_W-1:0]         i_a_den,
    input  logic signed [rau_pkg::NUM_W-1:0]  i_b_num,
    input  logic [rau_pkg::DEN_W-1:0]         i_b_den,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rau_pkg::RES_W-1:0]  o_res_num,
    output logic [rau_pkg::RES_W-2:0]         o_res_den,
    output logic                              o_valid_res
);

    rau_pkg::t_job_wr  wr;
    rau_pkg::t_job     q_job;
    logic              q_empty;
    logic              q_pop;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_push   (push),
        .i_q_full (full),
        .i_kind   (i_kind),
        .i_a_num  (i_a_num),
        .i_a_den  (i_a_den),
        .i_b_num  (i_b_num),
        .i_b_den  (i_b_den),
        .o_wr     (wr)
    );

    rau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    rau_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_job),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_valid_res (o_valid_res)
    );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic unit. Directed fractions
// cover field extremes, every operation, division by zero, zero
// denominators and negative divisors. Random fractions follow. Each word
// is predicted by exact cross multiply and Euclidean reduction, and the
// results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        rau_pkg::t_kind                    kind;
        logic signed [rau_pkg::NUM_W-1:0]  an;
        logic        [rau_pkg::DEN_W-1:0]  ad;
        logic signed [rau_pkg::NUM_W-1:0]  bn;
        logic        [rau_pkg::DEN_W-1:0]  bd;
    } t_frac_op;

    typedef struct {
        logic signed [rau_pkg::RES_W-1:0]  num;
        logic        [rau_pkg::RES_W-2:0]  den;
        logic                              ok;
    } t_frac_res;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              push;
    logic                              full;
    logic [1:0]                        i_kind;
    logic signed [rau_pkg::NUM_W-1:0]  i_a_num;
    logic [rau_pkg::DEN_W-1:0]         i_a_den;
    logic signed [rau_pkg::NUM_W-1:0]  i_b_num;
    logic [rau_pkg::DEN_W-1:0]         i_b_den;
    logic                              empty;
    logic                              pop;
    logic signed [rau_pkg::RES_W-1:0]  o_res_num;
    logic [rau_pkg::RES_W-2:0]         o_res_den;
    logic                              o_valid_res;

    t_frac_op   pending_ops[$];
    t_frac_res  reduced_fracs[$];
    int         n_errors = 0;
    int         n_checked = 0;
    int         n_invalid = 0;
    int         cycle_count = 0;
    int         send_gap;
    int         pop_gap;
    int         hold_off;
    bit         stim_done;

    rational_arith_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_kind     (i_kind),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .empty      (empty),
        .pop        (pop),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_valid_res(o_valid_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Euclidean gcd on magnitudes
    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // exact fraction result of one operation, reduced
    function automatic t_frac_res reduce_frac(t_frac_op op);
        t_frac_res          res;
        logic signed [63:0] an, ad, bn, bd, num, den;
        logic [63:0]        un, ud, g;
        logic               neg;
        an = op.an;
        bn = op.bn;
        ad = {33'd0, op.ad};
        bd = {33'd0, op.bd};
        case (op.kind)
            rau_pkg::KIND_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
            rau_pkg::KIND_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
            rau_pkg::KIND_MUL: begin num = an * bn;           den = ad * bd; end
            default:           begin num = an * bd;           den = ad * bn; end
        endcase
        if ((op.kind == rau_pkg::KIND_DIV && bn == 0) || den == 0) begin
            res.num = '0;
            res.den = 63'd1;
            res.ok  = 1'b0;
            return res;
        end
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        g   = gcd64(un, ud);
        un  = un / g;
        ud  = ud / g;
        if (un == 0) neg = 1'b0;
        res.num = neg ? -un : un;
        res.den = ud[62:0];
        res.ok  = 1'b1;
        return res;
    endfunction

    function automatic logic [31:0] rand_num();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 4))
            0: return 31'($urandom_range(1, 12));
            1: return 31'($urandom_range(1, 5000));
            default: return 31'($urandom_range(1, 32'h7fff_ffff));
        endcase
    endfunction

    task automatic add_op(rau_pkg::t_kind k, logic [31:0] an, logic [30:0] ad,
                          logic [31:0] bn, logic [30:0] bd);
        t_frac_op op;
        op.kind = k;
        op.an = an;
        op.ad = ad;
        op.bn = bn;
        op.bd = bd;
        pending_ops.push_back(op);
    endtask

    // fill the stimulus queue: directed corners, then random fractions
    initial begin
        t_frac_op op;
        for (int k = 0; k < 4; k++) begin
            add_op(rau_pkg::t_kind'(k), 32'h8000_0000, 31'h7fff_ffff,
                   32'h7fff_ffff, 31'd1);
            add_op(rau_pkg::t_kind'(k), 32'h7fff_ffff, 31'd1,
                   32'h8000_0000, 31'h7fff_ffff);
            add_op(rau_pkg::t_kind'(k), 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        end
        add_op(rau_pkg::KIND_DIV, 32'd5, 31'd3, 32'd0, 31'd7);     // divide by zero
        add_op(rau_pkg::KIND_ADD, 32'd1, 31'd0, 32'd2, 31'd3);     // zero denominator
        add_op(rau_pkg::KIND_MUL, 32'd1, 31'd4, 32'd2, 31'd0);
        add_op(rau_pkg::KIND_DIV, 32'd3, 31'd4, -32'sd6, 31'd5);   // negative divisor
        add_op(rau_pkg::KIND_SUB, 32'd3, 31'd7, 32'd3, 31'd7);     // zero result
        add_op(rau_pkg::KIND_ADD, 32'd0, 31'd1, 32'd0, 31'd1);
        add_op(rau_pkg::KIND_MUL, 32'hffff_ffff, 31'h5555_5555,
               32'h5555_5555, 31'h2aaa_aaaa);
        add_op(rau_pkg::KIND_ADD, 32'd6, 31'd4, 32'd10, 31'd4);
        for (int i = 0; i < 2000; i++) begin
            op.kind = rau_pkg::t_kind'($urandom_range(0, 3));
            op.an = rand_num();
            op.bn = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_num();
            op.ad = rand_den();
            op.bd = rand_den();
            if ($urandom_range(0, 99) == 0) op.ad = 31'd0;
            pending_ops.push_back(op);
        end
        stim_done = 1'b1;
    end

    // reset
    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // drive words: hold until full drops, then draw a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_kind <= '0;
            i_a_num <= '0;
            i_a_den <= '0;
            i_b_num <= '0;
            i_b_den <= '0;
            send_gap <= 0;
        end else if (push && full) begin
            // hold word
        end else if (send_gap > 0 && !push) begin
            send_gap <= send_gap - 1;
        end else if (push && send_gap > 0) begin
            push <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_ops.size() > 0) begin
            // a word taken at this edge is followed at once by the next
            t_frac_op op;
            op = pending_ops.pop_front();
            reduced_fracs.push_back(reduce_frac(op));
            push <= 1'b1;
            i_kind <= op.kind;
            i_a_num <= op.an;
            i_a_den <= op.ad;
            i_b_num <= op.bn;
            i_b_den <= op.bd;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end else begin
            push <= 1'b0;
        end
    end

    // pop results: long hold-off once, then random stalls
    always @(posedge i_clk) begin
        t_frac_res exp_res;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_gap <= 0;
            hold_off <= 3000;
        end else begin
            if (pop && !empty) begin
                if (reduced_fracs.size() == 0) begin
                    $display("%0t: result with nothing expected: %0d/%0d valid %0b",
                             $time, o_res_num, o_res_den, o_valid_res);
                    n_errors++;
                end else begin
                    exp_res = reduced_fracs.pop_front();
                    n_checked++;
                    if (!exp_res.ok) n_invalid++;
                    if (o_res_num !== exp_res.num) begin
                        $display("%0t: res_num expected %0d actual %0d",
                                 $time, exp_res.num, o_res_num);
                        n_errors++;
                    end
                    if (o_res_den !== exp_res.den) begin
                        $display("%0t: res_den expected %0d actual %0d",
                                 $time, exp_res.den, o_res_den);
                        n_errors++;
                    end
                    if (o_valid_res !== exp_res.ok) begin
                        $display("%0t: valid_res expected %0b actual %0b",
                                 $time, exp_res.ok, o_valid_res);
                        n_errors++;
                    end
                end
            end
            if (hold_off > 0 && n_checked >= 40) begin
                hold_off <= hold_off - 1;
                pop <= 1'b0;
            end else if (pop && !empty) begin
                pop_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // end of run: drain, settle, report
    initial begin
        wait (stim_done);
        while (!(i_rst_n && pending_ops.size() == 0 && reduced_fracs.size() == 0))
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Checked %0d fraction results over all four operations, %0d invalid",
                 n_checked, n_invalid);
        if (n_errors == 0 && reduced_fracs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rau_pkg.sv
hw/rtl/rau_front.sv
hw/rtl/rau_fifo.sv
hw/rtl/rau_back.sv
hw/rtl/rational_arith_unit.sv
verif/tb_top.sv
